FILE: src/fpc_pkg.sv
// Shared types, codes and constants for the frame pacing clock.
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

    localparam int unsigned TIME_BITS_DEF = 64;
    localparam int unsigned CFG_DATA_BITS = 64;
    localparam int unsigned CFG_IDX_BITS  = 3;
    localparam int unsigned WARMUP_WAIT   = 5000;
    localparam int unsigned ERROR_LIMIT   = 10;
    localparam logic [7:0]  ERROR_MAX     = 8'hff;

    localparam logic [31:0] NORMAL_INTERVAL_RST   = 32'd33333;
    localparam logic [31:0] SOFT_MIN_INTERVAL_RST = 32'd50000;
    localparam logic [31:0] HANG_THRESHOLD_RST    = 32'd1000000;
    localparam logic [31:0] STALL_DIAG_PERIOD_RST = 32'd5000000;
    localparam logic [31:0] YIELD_PERIOD_RST      = 32'd0;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NORMAL_INTERVAL   = 3'd0,
        REG_SOFT_MIN_INTERVAL = 3'd1,
        REG_HANG_THRESHOLD    = 3'd2,
        REG_STALL_DIAG_PERIOD = 3'd3,
        REG_YIELD_PERIOD      = 3'd4,
        REG_WARMUP_END        = 3'd5,
        REG_SOFT_START_END    = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_WARMUP = 2'd0,
        ACT_WAIT   = 2'd1,
        ACT_DECODE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        RC_OK  = 2'd0,
        RC_EOS = 2'd1
    } result_code_t;

    localparam logic MODE_POLL = 1'b0;

    typedef struct packed {
        logic [31:0] normal_interval;
        logic [31:0] soft_min_interval;
        logic [31:0] hang_threshold;
        logic [31:0] stall_diag_period;
        logic [31:0] yield_period;
    } cfg32_t;

    typedef struct packed {
        logic soft_start_done;
        logic stall_seen;
        logic yield_request;
        logic diag_request;
        logic delay_tick;
        logic stream_done;
        logic error_state;
    } flags_t;

endpackage

`default_nettype wire

FILE: src/fpc_cfg.sv
// Configuration register file of the frame pacing clock.
`timescale 1ns / 1ps
`default_nettype none

module fpc_cfg #(
    parameter int unsigned TIME_BITS = fpc_pkg::TIME_BITS_DEF
) (
    input  wire  logic                               clk,
    input  wire  logic                               rst_n,
    input  wire  logic                               cfg_we,
    input  wire  logic [fpc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  logic [fpc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output fpc_pkg::cfg32_t                          cfg32,
    output logic [TIME_BITS-1:0]                     warmup_end,
    output logic [TIME_BITS-1:0]                     soft_start_end
);
    import fpc_pkg::*;

    cfg32_t               cfg32_reg;
    logic [TIME_BITS-1:0] warmup_end_reg;
    logic [TIME_BITS-1:0] soft_start_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg32_reg.normal_interval   <= NORMAL_INTERVAL_RST;
            cfg32_reg.soft_min_interval <= SOFT_MIN_INTERVAL_RST;
            cfg32_reg.hang_threshold    <= HANG_THRESHOLD_RST;
            cfg32_reg.stall_diag_period <= STALL_DIAG_PERIOD_RST;
            cfg32_reg.yield_period      <= YIELD_PERIOD_RST;
            warmup_end_reg              <= '0;
            soft_start_end_reg          <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_NORMAL_INTERVAL:   cfg32_reg.normal_interval   <= cfg_wdata[31:0];
                REG_SOFT_MIN_INTERVAL: cfg32_reg.soft_min_interval <= cfg_wdata[31:0];
                REG_HANG_THRESHOLD:    cfg32_reg.hang_threshold    <= cfg_wdata[31:0];
                REG_STALL_DIAG_PERIOD: cfg32_reg.stall_diag_period <= cfg_wdata[31:0];
                REG_YIELD_PERIOD:      cfg32_reg.yield_period      <= cfg_wdata[31:0];
                REG_WARMUP_END:        warmup_end_reg     <= cfg_wdata[TIME_BITS-1:0];
                REG_SOFT_START_END:    soft_start_end_reg <= cfg_wdata[TIME_BITS-1:0];
                default:               ;
            endcase
        end
    end

    assign cfg32          = cfg32_reg;
    assign warmup_end     = warmup_end_reg;
    assign soft_start_end = soft_start_end_reg;

endmodule

`default_nettype wire

FILE: src/fpc_core.sv
// Result and next-state logic for one item of the frame pacing clock.
`timescale 1ns / 1ps
`default_nettype none

module fpc_core #(
    parameter int unsigned TIME_BITS = fpc_pkg::TIME_BITS_DEF
) (
    input  wire  fpc_pkg::cfg32_t    cfg32,
    input  wire  logic [TIME_BITS-1:0] warmup_end,
    input  wire  logic [TIME_BITS-1:0] soft_start_end,
    input  wire  logic               mode,
    input  wire  logic [TIME_BITS-1:0] now,
    input  wire  logic [1:0]         code,
    input  wire  logic [31:0]        frame_interval,
    input  wire  logic [TIME_BITS-1:0] next_deadline,
    input  wire  logic [TIME_BITS-1:0] last_success,
    input  wire  logic [TIME_BITS-1:0] last_diag,
    input  wire  logic [31:0]        yield_phase,
    input  wire  logic [7:0]         error_count,
    output logic [31:0]              frame_interval_next,
    output logic [TIME_BITS-1:0]     next_deadline_next,
    output logic [TIME_BITS-1:0]     last_success_next,
    output logic [TIME_BITS-1:0]     last_diag_next,
    output logic [31:0]              yield_phase_next,
    output logic [7:0]               error_count_next,
    output logic [1:0]               action,
    output logic [TIME_BITS-1:0]     wait_time,
    output fpc_pkg::flags_t          flags
);
    import fpc_pkg::*;

    logic [31:0]          fi_upd;
    logic                 soft_done;
    logic [TIME_BITS-1:0] since_success;
    logic [TIME_BITS-1:0] since_diag;
    logic                 stall;
    logic                 diag;
    logic [TIME_BITS-1:0] now_plus_fi;
    logic [32:0]          phase_inc;
    logic [7:0]           err_inc;

    always_comb
    begin
        // Soft start raises the interval to its floor; afterwards the normal
        // interval comes back once, and that poll is flagged.
        fi_upd    = frame_interval;
        soft_done = 1'b0;
        if (soft_start_end > now)
        begin
            if (frame_interval < cfg32.soft_min_interval)
                fi_upd = cfg32.soft_min_interval;
        end
        else if (frame_interval != cfg32.normal_interval)
        begin
            fi_upd    = cfg32.normal_interval;
            soft_done = 1'b1;
        end
    end

    assign since_success = now - last_success;
    assign since_diag    = now - last_diag;
    assign stall         = since_success > TIME_BITS'(cfg32.hang_threshold);
    assign diag          = since_diag > TIME_BITS'(cfg32.stall_diag_period);
    assign phase_inc     = {1'b0, yield_phase} + 33'd1;
    assign err_inc       = (error_count < ERROR_MAX) ? error_count + 8'd1 : error_count;

    always_comb
    begin
        frame_interval_next = frame_interval;
        next_deadline_next  = next_deadline;
        last_success_next   = last_success;
        last_diag_next      = last_diag;
        yield_phase_next    = yield_phase;
        error_count_next    = error_count;
        action              = ACT_WARMUP;
        wait_time           = '0;
        flags               = '0;
        now_plus_fi         = now + TIME_BITS'(frame_interval);

        if (mode == MODE_POLL)
        begin
            if (warmup_end > now)
            begin
                action    = ACT_WARMUP;
                wait_time = TIME_BITS'(WARMUP_WAIT);
            end
            else
            begin
                frame_interval_next   = fi_upd;
                flags.soft_start_done = soft_done;
                now_plus_fi           = now + TIME_BITS'(fi_upd);
                if (stall)
                begin
                    flags.stall_seen    = 1'b1;
                    flags.yield_request = 1'b1;
                    flags.diag_request  = diag;
                    if (diag)
                        last_diag_next = now;
                    next_deadline_next = now_plus_fi;
                    action             = ACT_WAIT;
                    wait_time          = TIME_BITS'(fi_upd);
                end
                else if (now >= next_deadline)
                begin
                    action = ACT_DECODE;
                end
                else
                begin
                    action    = ACT_WAIT;
                    wait_time = next_deadline - now;
                end
            end
        end
        else
        begin
            case (code)
                RC_OK:
                begin
                    last_success_next  = now;
                    error_count_next   = '0;
                    next_deadline_next = now_plus_fi;
                    if (cfg32.yield_period == 32'd0)
                        yield_phase_next = '0;
                    else if (phase_inc >= {1'b0, cfg32.yield_period})
                    begin
                        yield_phase_next = '0;
                        flags.delay_tick = 1'b1;
                    end
                    else
                        yield_phase_next = phase_inc[31:0];
                end
                RC_EOS:
                begin
                    next_deadline_next = now;
                    last_success_next  = now;
                    flags.stream_done  = 1'b1;
                end
                default:
                begin
                    error_count_next  = err_inc;
                    flags.error_state = err_inc > 8'(ERROR_LIMIT);
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/video_frame_pacing_clock_unit.sv
// Top level of the frame pacing clock: input register, state, result register.
// An accepted item waits in the input register; the result register loads from it once
// that register is free or being emptied, so a stall on out_ready holds the item there.
// Throughput: one item per cycle while out_ready does not stall the result register; the
// state update is one pass of compares and adds between the input and result registers.
// Reset: asynchronous, active low; clears the pacing state and both valid flags
// and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module video_frame_pacing_clock_unit #(
    parameter int unsigned TIME_BITS = fpc_pkg::TIME_BITS_DEF
) (
    input  wire  logic                               clk,
    input  wire  logic                               rst_n,
    input  wire  logic                               cfg_we,
    input  wire  logic [fpc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  logic [fpc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire  logic                               in_valid,
    output logic                                     in_ready,
    input  wire  logic                               mode,
    input  wire  logic [TIME_BITS-1:0]               now_time,
    input  wire  logic [1:0]                         result_code,
    output logic                                     out_valid,
    input  wire  logic                               out_ready,
    output logic [1:0]                               action,
    output logic [TIME_BITS-1:0]                     wait_time,
    output logic                                     soft_start_done,
    output logic                                     stall_seen,
    output logic                                     yield_request,
    output logic                                     diag_request,
    output logic                                     delay_tick,
    output logic                                     stream_done,
    output logic                                     error_state
);
    import fpc_pkg::*;

    cfg32_t               cfg32;
    logic [TIME_BITS-1:0] warmup_end;
    logic [TIME_BITS-1:0] soft_start_end;

    logic                 in_valid_reg;
    logic                 mode_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [1:0]           code_reg;

    logic [31:0]          frame_interval_reg;
    logic [TIME_BITS-1:0] next_deadline_reg;
    logic [TIME_BITS-1:0] last_success_reg;
    logic [TIME_BITS-1:0] last_diag_reg;
    logic [31:0]          yield_phase_reg;
    logic [7:0]           error_count_reg;

    logic [31:0]          frame_interval_next;
    logic [TIME_BITS-1:0] next_deadline_next;
    logic [TIME_BITS-1:0] last_success_next;
    logic [TIME_BITS-1:0] last_diag_next;
    logic [31:0]          yield_phase_next;
    logic [7:0]           error_count_next;
    logic [1:0]           action_next;
    logic [TIME_BITS-1:0] wait_time_next;
    flags_t               flags_next;

    logic                 out_valid_reg;
    logic [1:0]           action_reg;
    logic [TIME_BITS-1:0] wait_time_reg;
    flags_t               flags_reg;

    logic                 advance;

    // An item moves on whenever the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    fpc_cfg #(
        .TIME_BITS(TIME_BITS)
    ) u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cfg32         (cfg32),
        .warmup_end    (warmup_end),
        .soft_start_end(soft_start_end)
    );

    fpc_core #(
        .TIME_BITS(TIME_BITS)
    ) u_core (
        .cfg32              (cfg32),
        .warmup_end         (warmup_end),
        .soft_start_end     (soft_start_end),
        .mode               (mode_reg),
        .now                (now_reg),
        .code               (code_reg),
        .frame_interval     (frame_interval_reg),
        .next_deadline      (next_deadline_reg),
        .last_success       (last_success_reg),
        .last_diag          (last_diag_reg),
        .yield_phase        (yield_phase_reg),
        .error_count        (error_count_reg),
        .frame_interval_next(frame_interval_next),
        .next_deadline_next (next_deadline_next),
        .last_success_next  (last_success_next),
        .last_diag_next     (last_diag_next),
        .yield_phase_next   (yield_phase_next),
        .error_count_next   (error_count_next),
        .action             (action_next),
        .wait_time          (wait_time_next),
        .flags              (flags_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            frame_interval_reg <= '0;
            next_deadline_reg  <= '0;
            last_success_reg   <= '0;
            last_diag_reg      <= '0;
            yield_phase_reg    <= '0;
            error_count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg      <= 1'b1;
                frame_interval_reg <= frame_interval_next;
                next_deadline_reg  <= next_deadline_next;
                last_success_reg   <= last_success_next;
                last_diag_reg      <= last_diag_next;
                yield_phase_reg    <= yield_phase_next;
                error_count_reg    <= error_count_next;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg <= mode;
            now_reg  <= now_time;
            code_reg <= result_code;
        end
        if (advance)
        begin
            action_reg    <= action_next;
            wait_time_reg <= wait_time_next;
            flags_reg     <= flags_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign wait_time       = wait_time_reg;
    assign soft_start_done = flags_reg.soft_start_done;
    assign stall_seen      = flags_reg.stall_seen;
    assign yield_request   = flags_reg.yield_request;
    assign diag_request    = flags_reg.diag_request;
    assign delay_tick      = flags_reg.delay_tick;
    assign stream_done     = flags_reg.stream_done;
    assign error_state     = flags_reg.error_state;

endmodule

`default_nettype wire

FILE: dv/fpc_checker.sv
// Checker for the frame pacing clock: mirrors its state, predicts each result item and compares.
`timescale 1ns / 1ps
`default_nettype none

module fpc_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [fpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [fpc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic                                mode,
    input  wire logic [fpc_pkg::TIME_BITS_DEF-1:0]   now_time,
    input  wire logic [1:0]                          result_code,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic [1:0]                          action,
    input  wire logic [fpc_pkg::TIME_BITS_DEF-1:0]   wait_time,
    input  wire logic                                soft_start_done,
    input  wire logic                                stall_seen,
    input  wire logic                                yield_request,
    input  wire logic                                diag_request,
    input  wire logic                                delay_tick,
    input  wire logic                                stream_done,
    input  wire logic                                error_state,
    output int                                       mismatch_total,
    output int                                       answers_due
);
    import fpc_pkg::*;

    localparam int unsigned TW = TIME_BITS_DEF;

    typedef struct {
        action_t        action;
        logic [TW-1:0]  wait_time;
        flags_t         flags;
    } pace_answer_t;

    pace_answer_t pending_answers[$];

    // Shadow of the configuration registers.
    cfg32_t         shadow_cfg;
    logic [TW-1:0]  warm_end;
    logic [TW-1:0]  soft_end;

    // Shadow of the pacing state.
    logic [31:0]    interval;
    logic [TW-1:0]  deadline;
    logic [TW-1:0]  last_frame;
    logic [TW-1:0]  last_success;
    logic [TW-1:0]  last_diag;
    logic [31:0]    frames;
    logic [31:0]    yield_phase;
    logic [7:0]     errors;
    int             misses;

    function automatic pace_answer_t pace_answer(input logic m, input logic [TW-1:0] now,
                                                 input logic [1:0] code);
        pace_answer_t r;
        logic [32:0]  next_phase;
        r.action    = ACT_WARMUP;
        r.wait_time = '0;
        r.flags     = '0;
        if (m == MODE_POLL) begin
            if (warm_end > now) begin
                r.wait_time = TW'(WARMUP_WAIT);
            end else begin
                if (soft_end > now) begin
                    if (interval < shadow_cfg.soft_min_interval)
                        interval = shadow_cfg.soft_min_interval;
                end else if (interval != shadow_cfg.normal_interval) begin
                    interval = shadow_cfg.normal_interval;
                    r.flags.soft_start_done = 1'b1;
                end
                if (TW'(now - last_success) > TW'(shadow_cfg.hang_threshold)) begin
                    r.flags.stall_seen    = 1'b1;
                    r.flags.yield_request = 1'b1;
                    if (TW'(now - last_diag) > TW'(shadow_cfg.stall_diag_period)) begin
                        last_diag = now;
                        r.flags.diag_request = 1'b1;
                    end
                    deadline    = now + TW'(interval);
                    r.action    = ACT_WAIT;
                    r.wait_time = TW'(interval);
                end else if (now >= deadline) begin
                    r.action = ACT_DECODE;
                end else begin
                    r.action    = ACT_WAIT;
                    r.wait_time = deadline - now;
                end
            end
        end else if (code == RC_OK) begin
            last_frame   = now;
            last_success = now;
            frames       = frames + 32'd1;
            errors       = '0;
            deadline     = now + TW'(interval);
            if (shadow_cfg.yield_period == 32'd0) begin
                yield_phase = '0;
            end else begin
                next_phase = {1'b0, yield_phase} + 33'd1;
                if (next_phase >= {1'b0, shadow_cfg.yield_period}) begin
                    yield_phase = '0;
                    r.flags.delay_tick = 1'b1;
                end else begin
                    yield_phase = next_phase[31:0];
                end
            end
        end else if (code == RC_EOS) begin
            deadline     = now;
            last_success = now;
            r.flags.stream_done = 1'b1;
        end else begin
            // Both the error code and the spare code count as errors.
            if (errors != ERROR_MAX)
                errors = errors + 8'd1;
            r.flags.error_state = (errors > ERROR_LIMIT);
        end
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [TW-1:0] want_v,
                                         input logic [TW-1:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        pace_answer_t want;
        int           bad;
        if (!rst_n) begin
            shadow_cfg.normal_interval   = NORMAL_INTERVAL_RST;
            shadow_cfg.soft_min_interval = SOFT_MIN_INTERVAL_RST;
            shadow_cfg.hang_threshold    = HANG_THRESHOLD_RST;
            shadow_cfg.stall_diag_period = STALL_DIAG_PERIOD_RST;
            shadow_cfg.yield_period      = YIELD_PERIOD_RST;
            warm_end     = '0;
            soft_end     = '0;
            interval     = '0;
            deadline     = '0;
            last_frame   = '0;
            last_success = '0;
            last_diag    = '0;
            frames       = '0;
            yield_phase  = '0;
            errors       = '0;
            misses       = 0;
            pending_answers.delete();
            mismatch_total <= 0;
            answers_due    <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_NORMAL_INTERVAL:   shadow_cfg.normal_interval   = cfg_wdata[31:0];
                    REG_SOFT_MIN_INTERVAL: shadow_cfg.soft_min_interval = cfg_wdata[31:0];
                    REG_HANG_THRESHOLD:    shadow_cfg.hang_threshold    = cfg_wdata[31:0];
                    REG_STALL_DIAG_PERIOD: shadow_cfg.stall_diag_period = cfg_wdata[31:0];
                    REG_YIELD_PERIOD:      shadow_cfg.yield_period      = cfg_wdata[31:0];
                    REG_WARMUP_END:        warm_end = cfg_wdata[TW-1:0];
                    REG_SOFT_START_END:    soft_end = cfg_wdata[TW-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (pending_answers.size() == 0) begin
                    $display("%0t: result item with nothing expected, action %0d wait_time %0h",
                             $time, action, wait_time);
                    misses++;
                end else begin
                    want = pending_answers.pop_front();
                    bad  = field_differs("action", TW'(want.action), TW'(action))
                         + field_differs("wait_time", want.wait_time, wait_time)
                         + field_differs("soft_start_done", TW'(want.flags.soft_start_done),
                                         TW'(soft_start_done))
                         + field_differs("stall_seen", TW'(want.flags.stall_seen),
                                         TW'(stall_seen))
                         + field_differs("yield_request", TW'(want.flags.yield_request),
                                         TW'(yield_request))
                         + field_differs("diag_request", TW'(want.flags.diag_request),
                                         TW'(diag_request))
                         + field_differs("delay_tick", TW'(want.flags.delay_tick),
                                         TW'(delay_tick))
                         + field_differs("stream_done", TW'(want.flags.stream_done),
                                         TW'(stream_done))
                         + field_differs("error_state", TW'(want.flags.error_state),
                                         TW'(error_state));
                    if (bad != 0)
                        misses++;
                end
            end
            if (in_valid && in_ready)
                pending_answers.push_back(pace_answer(mode, now_time, result_code));
            mismatch_total <= misses;
            answers_due    <= pending_answers.size();
        end
    end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Top of the frame pacing clock testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import fpc_pkg::*;

    localparam int unsigned TW          = TIME_BITS_DEF;
    localparam logic        MODE_REPORT = 1'b1;
    localparam logic [1:0]  RC_ERROR    = 2'd2;
    localparam logic [1:0]  RC_SPARE    = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;
    localparam logic [TW-1:0] TIME_MAX  = '1;
    localparam int unsigned ITEM_GOAL   = 900;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned ERROR_RUN   = 260;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_wdata = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       mode = MODE_POLL;
    logic [TW-1:0]              now_time = '0;
    logic [1:0]                 result_code = RC_OK;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [1:0]                 action;
    logic [TW-1:0]              wait_time;
    logic                       soft_start_done;
    logic                       stall_seen;
    logic                       yield_request;
    logic                       diag_request;
    logic                       delay_tick;
    logic                       stream_done;
    logic                       error_state;

    int                         mismatch_total;
    int                         answers_due;

    // Stimulus state; quiet and hold_req are shared with the receiver process.
    bit                         quiet = 1'b0;
    bit                         hold_req = 1'b0;
    int                         items_sent = 0;
    logic [TW-1:0]              cur_time = '0;
    logic [31:0]                step_max = 32'd16;
    logic [31:0]                hang_cfg = HANG_THRESHOLD_RST;

    video_frame_pacing_clock_unit #(
        .TIME_BITS(TW)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .now_time(now_time),
        .result_code(result_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .action(action),
        .wait_time(wait_time),
        .soft_start_done(soft_start_done),
        .stall_seen(stall_seen),
        .yield_request(yield_request),
        .diag_request(diag_request),
        .delay_tick(delay_tick),
        .stream_done(stream_done),
        .error_state(error_state)
    );

    fpc_checker u_check (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .now_time(now_time),
        .result_code(result_code),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .action(action),
        .wait_time(wait_time),
        .soft_start_done(soft_start_done),
        .stall_seen(stall_seen),
        .yield_request(yield_request),
        .diag_request(diag_request),
        .delay_tick(delay_tick),
        .stream_done(stream_done),
        .error_state(error_state),
        .mismatch_total(mismatch_total),
        .answers_due(answers_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(5_000_000);
        $display("Regression FAIL");
        $finish;
    end

    // Result side: random stall bursts, and one long hold-off when asked.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16) - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic send(input logic m, input logic [TW-1:0] t, input logic [1:0] c);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        now_time    <= t;
        result_code <= c;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (answers_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [63:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [63:0] ni, input logic [63:0] smi,
                               input logic [63:0] ht, input logic [63:0] sdp,
                               input logic [63:0] yp, input logic [63:0] we,
                               input logic [63:0] sse);
        write_reg(REG_NORMAL_INTERVAL, ni);
        write_reg(REG_SOFT_MIN_INTERVAL, smi);
        write_reg(REG_HANG_THRESHOLD, ht);
        write_reg(REG_STALL_DIAG_PERIOD, sdp);
        write_reg(REG_YIELD_PERIOD, yp);
        write_reg(REG_WARMUP_END, we);
        write_reg(REG_SOFT_START_END, sse);
        write_reg(REG_UNUSED, {$urandom, $urandom});
        cfg_we   <= 1'b0;
        step_max = (ni[31:0] >> 1) + 32'd16;
        hang_cfg = ht[31:0];
    endtask

    initial
    begin
        int          kind;
        int          n;
        int          goal;
        bit          paused;
        logic [63:0] ni;
        logic [63:0] smi;
        logic [63:0] ht;
        logic [63:0] sdp;
        logic [63:0] yp;
        logic [63:0] we;
        logic [63:0] sse;

        paused = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset configuration.
        send(MODE_POLL, 64'd0, RC_OK);
        send(MODE_REPORT, 64'd0, RC_OK);
        send(MODE_POLL, 64'd10, RC_OK);
        send(MODE_POLL, 64'd33333, RC_OK);
        send(MODE_REPORT, 64'd40000, RC_EOS);
        send(MODE_REPORT, 64'd40001, RC_ERROR);
        send(MODE_REPORT, 64'd40002, RC_SPARE);
        send(MODE_POLL, TIME_MAX, RC_OK);
        send(MODE_POLL, TIME_MAX, RC_OK);
        send(MODE_REPORT, TIME_MAX, RC_OK);
        // The time has wrapped past zero since the last good frame.
        send(MODE_POLL, 64'd5, RC_OK);
        drain();

        // Warm-up, soft start and its end, the yield period, deadline and stall boundaries.
        load_config(64'd33333, 64'd50000, 64'd1000000, 64'd5000000, 64'd2, 64'd1000, 64'd2000);
        send(MODE_POLL, 64'd500, RC_OK);
        send(MODE_POLL, 64'd1000, RC_OK);
        send(MODE_POLL, 64'd1500, RC_OK);
        send(MODE_REPORT, 64'd1600, RC_OK);
        send(MODE_REPORT, 64'd1700, RC_OK);
        send(MODE_POLL, 64'd51700, RC_OK);
        send(MODE_POLL, 64'd1001700, RC_OK);
        send(MODE_POLL, 64'd1001701, RC_OK);
        drain();

        cur_time = 64'd3000000;
        for (int ph = 1; ph < PHASES; ph++)
        begin
            case (ph)
                2:
                begin
                    ni = '0; smi = '0; ht = '0; sdp = '0; yp = '0; we = '0; sse = '0;
                end
                3:
                begin
                    ni = '1; smi = '1; ht = '1; sdp = '1; yp = '1; we = '1; sse = '1;
                end
                5:
                begin
                    ni  = {$urandom, 32'($urandom_range(1000, 60000))};
                    smi = {$urandom, 32'($urandom_range(1000, 90000))};
                    ht  = {$urandom, 32'($urandom_range(50000, 400000))};
                    sdp = {$urandom, 32'($urandom_range(0, 1000000))};
                    yp  = {$urandom, 32'd1};
                    we  = cur_time + 64'($urandom_range(0, 200000));
                    sse = cur_time + 64'($urandom_range(0, 400000));
                end
                default:
                begin
                    ni  = {$urandom, 32'($urandom_range(1000, 60000))};
                    smi = {$urandom, 32'($urandom_range(1000, 90000))};
                    ht  = {$urandom, 32'($urandom_range(50000, 400000))};
                    sdp = {$urandom, 32'($urandom_range(0, 1000000))};
                    yp  = {$urandom, 32'($urandom_range(0, 6))};
                    we  = cur_time + 64'($urandom_range(0, 200000));
                    sse = cur_time + 64'($urandom_range(0, 400000));
                end
            endcase
            load_config(ni, smi, ht, sdp, yp, we, sse);
            quiet = (ph == PHASES - 1);

            if (ph == 1)
            begin
                // Long result hold-off while a run of errors drives the count into saturation.
                hold_req = 1'b1;
                repeat (ERROR_RUN)
                begin
                    cur_time = cur_time + 64'($urandom_range(0, 100));
                    send(MODE_REPORT, cur_time, ($urandom_range(0, 1) == 0) ? RC_ERROR : RC_SPARE);
                end
            end

            // The error run above takes its share out of the item budget.
            goal = items_sent + (ITEM_GOAL - ERROR_RUN) / (PHASES - 1);
            while (items_sent < goal)
            begin
                if (ph == 4 && !paused && items_sent > goal - 60)
                begin
                    drain();
                    paused = 1'b1;
                end
                kind = $urandom_range(0, 99);
                if (kind < 55)
                begin
                    // One frame: a few polls as time moves on, then the decode report.
                    n = $urandom_range(0, 4);
                    repeat (n)
                    begin
                        cur_time = cur_time + 64'($urandom_range(0, step_max));
                        send(MODE_POLL, cur_time, RC_OK);
                    end
                    cur_time = cur_time + 64'($urandom_range(0, 200));
                    send(MODE_REPORT, cur_time, ($urandom_range(0, 9) == 0) ? RC_EOS : RC_OK);
                end
                else if (kind < 65)
                begin
                    n = $urandom_range(1, 14);
                    repeat (n)
                    begin
                        cur_time = cur_time + 64'($urandom_range(0, 100));
                        send(MODE_REPORT, cur_time,
                             ($urandom_range(0, 1) == 0) ? RC_ERROR : RC_SPARE);
                    end
                end
                else if (kind < 70)
                begin
                    cur_time = cur_time + 64'($urandom_range(0, step_max));
                    send(MODE_REPORT, cur_time, RC_EOS);
                    send(MODE_POLL, cur_time, RC_OK);
                end
                else if (kind < 80)
                begin
                    // Decoding stops for longer than the hang threshold.
                    cur_time = cur_time + 64'(hang_cfg) + 64'($urandom_range(1, 1000000));
                    n = $urandom_range(1, 5);
                    repeat (n)
                    begin
                        cur_time = cur_time + 64'($urandom_range(0, step_max));
                        send(MODE_POLL, cur_time, RC_OK);
                    end
                    if ($urandom_range(0, 1) == 0)
                        send(MODE_REPORT, cur_time, RC_OK);
                end
                else if (kind < 90)
                begin
                    n = $urandom_range(1, 3);
                    repeat (n)
                        send(logic'($urandom_range(0, 1)), {$urandom, $urandom},
                             2'($urandom_range(0, 3)));
                end
                else if (kind < 95)
                begin
                    cur_time = TIME_MAX - 64'($urandom_range(0, step_max));
                end
                else
                begin
                    // Polls exactly at and just past the hang threshold.
                    send(MODE_REPORT, cur_time, RC_OK);
                    send(MODE_POLL, cur_time + 64'(hang_cfg), RC_OK);
                    send(MODE_POLL, cur_time + 64'(hang_cfg) + 64'd1, RC_OK);
                    cur_time = cur_time + 64'(hang_cfg) + 64'd1;
                end
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatch_total == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
src/fpc_pkg.sv
src/fpc_cfg.sv
src/fpc_core.sv
src/video_frame_pacing_clock_unit.sv
dv/fpc_checker.sv
dv/testbench.sv
